@@ design/orrls_pkg.sv @@
// shared types and codes for the oldest-ready resource lock scheduler
`default_nettype none

package orrls_pkg;

   localparam int TAG_W = 8;
   localparam int RES_W = 5;

   // operation codes carried in the request word
   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_TAKE    = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [TAG_W-1:0] req_tag;
      logic [RES_W-1:0] res_a;
      logic [RES_W-1:0] res_b;
      logic [RES_W-1:0] res_c;
      logic             shutdown;
   } req_word_type;

   typedef struct packed {
      logic             granted;
      logic [TAG_W-1:0] grant_tag;
      logic             grant_shutdown;
      logic             queue_full;
   } rsp_word_type;

   // one queue slot
   typedef struct packed {
      logic             valid;
      logic [TAG_W-1:0] tag;
      logic [RES_W-1:0] res_a;
      logic [RES_W-1:0] res_b;
      logic [RES_W-1:0] res_c;
      logic             shutdown;
   } entry_type;

   // strobes from the sequencer to every slot
   typedef struct packed {
      logic load;
      logic check;
      logic shift;
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ design/orrls_cell.sv @@
// one queue slot: holds an entry, checks readiness, joins the oldest-first chain
`default_nettype none

module orrls_cell #(
   parameter int NUM_RESOURCES   = 16,
   parameter int RES_PER_REQUEST = 3
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire orrls_pkg::cell_ctrl_type ctrl,
   input  wire logic [NUM_RESOURCES:1]  busy,
   input  wire orrls_pkg::entry_type    load_entry,
   input  wire logic                    prev_valid,
   input  wire orrls_pkg::entry_type    next_entry,
   input  wire logic                    found_in,
   output logic                         found_out,
   output logic                         win,
   output orrls_pkg::entry_type         entry
);
   import orrls_pkg::*;

   entry_type entry_ff, entry_in;
   logic      ready_ff, ready_in;
   logic      hit;

   // decoded resource set of this entry, out-of-range and zero drop out
   function automatic logic [NUM_RESOURCES:1] res_mask(input logic [RES_W-1:0] ra,
                                                       input logic [RES_W-1:0] rb,
                                                       input logic [RES_W-1:0] rc);
      logic [RES_W-1:0]       list [3];
      logic [NUM_RESOURCES:1] m;
      list[0] = ra;
      list[1] = rb;
      list[2] = rc;
      m = '0;
      for (int k = 0; k < RES_PER_REQUEST; k++) begin
         for (int j = 1; j <= NUM_RESOURCES; j++) begin
            if ({1'b0, list[k]} == 6'(j)) begin
               m[j] = 1'b1;
            end
         end
      end
      return m;
   endfunction

   assign hit = |(res_mask(entry_ff.res_a, entry_ff.res_b, entry_ff.res_c) & busy);

   assign ready_in = ctrl.check ? (entry_ff.valid && (entry_ff.shutdown || !hit)) : ready_ff;

   // older ready slot blocks this one; found ripples toward the young end
   assign found_out = found_in | ready_ff;
   assign win       = ready_ff & ~found_in;

   always_comb begin
      priority if (ctrl.shift && found_out) begin
         entry_in = next_entry;
      end else if (ctrl.load && !entry_ff.valid && prev_valid) begin
         entry_in = load_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
         ready_ff       <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         ready_ff <= ready_in;
      end
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

@@ design/oldest_ready_resource_lock_scheduler_unit.sv @@
// top level of the oldest-ready resource lock scheduler: slot chain and sequencer
`default_nettype none

//  channel | direction | handshake              | word
//  req     | in        | req_valid / req_ready  | opcode, tag, three resources, shutdown
//  rsp     | out       | rsp_valid / rsp_ready  | granted, grant tag, grant shutdown, full
//
//  enqueue and release answer on acceptance; accepting a take latches every
//  slot's ready bit, then the take state runs the oldest-first chain, compacts the
//  queue and registers the grant; the found chain across all slots sets the pace
//  reset clears slot valid bits, the busy vector and the response valid bit
//  a take may be accepted while a response still waits; it then holds in the
//  take state until the response register frees up

module oldest_ready_resource_lock_scheduler_unit #(
   parameter int NUM_RESOURCES   = 16,
   parameter int RES_PER_REQUEST = 3,
   parameter int QUEUE_DEPTH     = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire orrls_pkg::req_word_type req_word,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output orrls_pkg::rsp_word_type      rsp_word
);
   import orrls_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_TAKE = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_word_ff, rsp_word_in;
   logic [NUM_RESOURCES:1] busy_ff, busy_in;

   logic          accept;
   logic          rsp_free;
   logic          take_done;
   cell_ctrl_type ctrl;
   entry_type     load_entry;
   entry_type     sel_entry;
   logic          any_ready;

   // slot chain wiring
   entry_type              entry_q [QUEUE_DEPTH];
   logic [QUEUE_DEPTH:0]   found;
   logic [QUEUE_DEPTH-1:0] win;

   // decoded resource set, index zero and out-of-range indexes drop out
   function automatic logic [NUM_RESOURCES:1] res_mask(input logic [RES_W-1:0] ra,
                                                       input logic [RES_W-1:0] rb,
                                                       input logic [RES_W-1:0] rc);
      logic [RES_W-1:0]       list [3];
      logic [NUM_RESOURCES:1] m;
      list[0] = ra;
      list[1] = rb;
      list[2] = rc;
      m = '0;
      for (int k = 0; k < RES_PER_REQUEST; k++) begin
         for (int j = 1; j <= NUM_RESOURCES; j++) begin
            if ({1'b0, list[k]} == 6'(j)) begin
               m[j] = 1'b1;
            end
         end
      end
      return m;
   endfunction

   // handshake
   assign rsp_free  = ~rsp_valid_ff | rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && (rsp_free || req_word.opcode == OP_TAKE);
   assign accept    = req_valid & req_ready;
   assign take_done = (state_ff == ST_TAKE) && rsp_free;

   assign ctrl.load  = accept && (req_word.opcode == OP_ENQUEUE);
   assign ctrl.check = accept && (req_word.opcode == OP_TAKE);
   assign ctrl.shift = take_done;

   always_comb begin
      load_entry.valid    = 1'b1;
      load_entry.tag      = req_word.req_tag;
      load_entry.res_a    = req_word.res_a;
      load_entry.res_b    = req_word.res_b;
      load_entry.res_c    = req_word.res_c;
      load_entry.shutdown = req_word.shutdown;
   end

   // slot 0 is the oldest; the first free slot sits right after the valid prefix
   assign found[0] = 1'b0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
      logic      prev_valid;
      entry_type next_entry;

      if (i == 0) begin : g_head
         assign prev_valid = 1'b1;
      end else begin : g_body
         assign prev_valid = entry_q[i-1].valid;
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign next_entry = '0;
      end else begin : g_mid
         assign next_entry = entry_q[i+1];
      end

      orrls_cell #(
         .NUM_RESOURCES   (NUM_RESOURCES),
         .RES_PER_REQUEST (RES_PER_REQUEST)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .busy       (busy_ff),
         .load_entry (load_entry),
         .prev_valid (prev_valid),
         .next_entry (next_entry),
         .found_in   (found[i]),
         .found_out  (found[i+1]),
         .win        (win[i]),
         .entry      (entry_q[i])
      );
   end

   assign any_ready = found[QUEUE_DEPTH];

   // winner is one-hot, so an and-or pick is enough
   always_comb begin
      sel_entry = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         sel_entry = sel_entry | (entry_q[i] & {$bits(entry_type){win[i]}});
      end
   end

   // busy bits: a grant of a non-shutdown entry marks, release frees
   always_comb begin
      priority if (take_done && any_ready && !sel_entry.shutdown) begin
         busy_in = busy_ff | res_mask(sel_entry.res_a, sel_entry.res_b, sel_entry.res_c);
      end else if (accept && req_word.opcode == OP_RELEASE) begin
         busy_in = busy_ff & ~res_mask(req_word.res_a, req_word.res_b, req_word.res_c);
      end else begin
         busy_in = busy_ff;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      priority if (take_done) begin
         rsp_valid_in               = 1'b1;
         rsp_word_in.granted        = any_ready;
         rsp_word_in.grant_tag      = any_ready ? sel_entry.tag : '0;
         rsp_word_in.grant_shutdown = any_ready & sel_entry.shutdown;
         rsp_word_in.queue_full     = 1'b0;
      end else if (accept && req_word.opcode != OP_TAKE) begin
         rsp_valid_in               = 1'b1;
         rsp_word_in.granted        = 1'b0;
         rsp_word_in.grant_tag      = '0;
         rsp_word_in.grant_shutdown = 1'b0;
         // full only when the youngest slot is taken
         rsp_word_in.queue_full     = (req_word.opcode == OP_ENQUEUE) &&
                                      entry_q[QUEUE_DEPTH-1].valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // sequencer
   always_comb begin
      unique case (state_ff)
         ST_IDLE: begin
            state_in = ctrl.check ? ST_TAKE : ST_IDLE;
         end
         ST_TAKE: begin
            state_in = take_done ? ST_IDLE : ST_TAKE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         busy_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         busy_ff      <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

@@ tb/sv/orrls_checker.sv @@
// scoreboard for the oldest-ready resource lock scheduler: predicts and compares response words
module orrls_checker #(
   parameter int NUM_RESOURCES   = 16,
   parameter int RES_PER_REQUEST = 3,
   parameter int QUEUE_DEPTH     = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  orrls_pkg::req_word_type req_word,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  orrls_pkg::rsp_word_type rsp_word,
   output int                     error_count,
   output int                     words_pending,
   output int                     grant_count,
   output int                     full_count
);

   timeunit 1ns;
   timeprecision 1ps;

   import orrls_pkg::*;

   // own copy of the queue and the lock bits
   entry_type                slots [QUEUE_DEPTH];
   logic [NUM_RESOURCES:0]   lock_busy;
   rsp_word_type             predicted_rsp_q [$];

   function automatic logic [RES_W-1:0] entry_res(entry_type e, int k);
      case (k)
         0:       return e.res_a;
         1:       return e.res_b;
         default: return e.res_c;
      endcase
   endfunction

   function automatic bit lockable(logic [RES_W-1:0] r);
      return r != '0 && int'(r) <= NUM_RESOURCES;
   endfunction

   function automatic bit slot_ready(entry_type e);
      logic [RES_W-1:0] r;
      if (e.shutdown) begin
         return 1'b1;
      end
      for (int k = 0; k < RES_PER_REQUEST; k++) begin
         r = entry_res(e, k);
         if (lockable(r) && lock_busy[r]) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // advances the shadow state by one request word and returns the response it owes
   function automatic rsp_word_type schedule_step(req_word_type w);
      rsp_word_type     rsp;
      entry_type        e;
      int               pick;
      logic [RES_W-1:0] r;
      rsp  = '0;
      pick = -1;
      case (w.opcode)
         OP_ENQUEUE: begin
            for (int i = 0; i < QUEUE_DEPTH && pick < 0; i++) begin
               if (!slots[i].valid) begin
                  pick = i;
               end
            end
            if (pick < 0) begin
               rsp.queue_full = 1'b1;
            end else begin
               e.valid    = 1'b1;
               e.tag      = w.req_tag;
               e.res_a    = w.res_a;
               e.res_b    = w.res_b;
               e.res_c    = w.res_c;
               e.shutdown = w.shutdown;
               slots[pick] = e;
            end
         end
         OP_TAKE: begin
            // oldest first
            for (int i = 0; i < QUEUE_DEPTH && pick < 0; i++) begin
               if (slots[i].valid && slot_ready(slots[i])) begin
                  pick = i;
               end
            end
            if (pick >= 0) begin
               e = slots[pick];
               rsp.granted        = 1'b1;
               rsp.grant_tag      = e.tag;
               rsp.grant_shutdown = e.shutdown;
               if (!e.shutdown) begin
                  for (int k = 0; k < RES_PER_REQUEST; k++) begin
                     r = entry_res(e, k);
                     if (lockable(r)) begin
                        lock_busy[r] = 1'b1;
                     end
                  end
               end
               // compact toward slot 0
               for (int i = pick; i < QUEUE_DEPTH - 1; i++) begin
                  slots[i] = slots[i+1];
               end
               slots[QUEUE_DEPTH-1].valid = 1'b0;
            end
         end
         OP_RELEASE: begin
            for (int k = 0; k < RES_PER_REQUEST; k++) begin
               r = (k == 0) ? w.res_a : (k == 1) ? w.res_b : w.res_c;
               if (lockable(r)) begin
                  lock_busy[r] = 1'b0;
               end
            end
         end
         default: begin
            // unused opcode leaves everything alone
         end
      endcase
      return rsp;
   endfunction

   task automatic check_field(string field, logic [TAG_W-1:0] exp_v, logic [TAG_W-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0d, got %0d", field, exp_v, act_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type predicted;
      if (reset) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            slots[i] = '0;
         end
         lock_busy = '0;
         predicted_rsp_q.delete();
         error_count = 0;
         grant_count = 0;
         full_count  = 0;
      end else begin
         // push first: a word returned at this edge always belongs to an older request
         if (req_valid && req_ready) begin
            predicted_rsp_q.push_back(schedule_step(req_word));
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsp_q.size() == 0) begin
               $error("response word with no request outstanding: %h", rsp_word);
               error_count++;
            end else begin
               predicted = predicted_rsp_q.pop_front();
               check_field("granted", predicted.granted, rsp_word.granted);
               check_field("grant_tag", predicted.grant_tag, rsp_word.grant_tag);
               check_field("grant_shutdown", predicted.grant_shutdown, rsp_word.grant_shutdown);
               check_field("queue_full", predicted.queue_full, rsp_word.queue_full);
               grant_count += predicted.granted;
               full_count  += predicted.queue_full;
            end
         end
      end
      words_pending <= predicted_rsp_q.size();
   end

endmodule

@@ tb/sv/tb_top.sv @@
// top of the scheduler testbench: clock, reset, request stimulus, response pacing and verdict
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import orrls_pkg::*;

   localparam int NUM_RESOURCES   = 16;
   localparam int RES_PER_REQUEST = 3;
   localparam int QUEUE_DEPTH     = 16;

   // the package names only the three live codes
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int RANDOM_WORDS = 1750;
   localparam int STALL_LIMIT  = 4000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_word;

   int error_count;
   int words_pending;
   int grant_count;
   int full_count;

   // pacing knobs, percent of cycles
   int send_idle_pct;
   int recv_stall_pct;
   int words_sent;
   int directed_words;
   int quiet_cycles;

   oldest_ready_resource_lock_scheduler_unit #(
      .NUM_RESOURCES   (NUM_RESOURCES),
      .RES_PER_REQUEST (RES_PER_REQUEST),
      .QUEUE_DEPTH     (QUEUE_DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   orrls_checker #(
      .NUM_RESOURCES   (NUM_RESOURCES),
      .RES_PER_REQUEST (RES_PER_REQUEST),
      .QUEUE_DEPTH     (QUEUE_DEPTH)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word      (rsp_word),
      .error_count   (error_count),
      .words_pending (words_pending),
      .grant_count   (grant_count),
      .full_count    (full_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // response side: ready decided at every falling edge
   always @(negedge clock) begin
      rsp_ready = reset ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog: cycles in a row with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_word_type make_word(logic [1:0] op, logic [TAG_W-1:0] tag,
                                              logic [RES_W-1:0] a, logic [RES_W-1:0] b,
                                              logic [RES_W-1:0] c, logic sh);
      req_word_type w;
      w.opcode   = op;
      w.req_tag  = tag;
      w.res_a    = a;
      w.res_b    = b;
      w.res_c    = c;
      w.shutdown = sh;
      return w;
   endfunction

   // mostly real resources, some none, some beyond the last index
   function automatic logic [RES_W-1:0] pick_resource();
      int p;
      p = $urandom_range(99);
      if (p < 10) begin
         return '0;
      end else if (p < 88) begin
         return RES_W'($urandom_range(NUM_RESOURCES, 1));
      end
      return RES_W'($urandom_range(31, NUM_RESOURCES + 1));
   endfunction

   // present one word from a falling edge and hold it until it is taken
   task automatic send_word(req_word_type w);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_word  = w;
      do begin
         @(posedge clock);
      end while (!req_ready);
      words_sent++;
   endtask

   task automatic send_random(logic [1:0] op);
      send_word(make_word(op, TAG_W'($urandom), pick_resource(), pick_resource(),
                          pick_resource(), ($urandom_range(9) == 0)));
   endtask

   initial begin
      int kind;
      int p;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_word       = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      words_sent     = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part, no idling
      send_word(make_word(OP_TAKE, 8'd0, 5'd0, 5'd0, 5'd0, 1'b0));      // empty queue
      send_word(make_word(OP_ENQUEUE, 8'd0, 5'd1, 5'd2, 5'd3, 1'b0));
      send_word(make_word(OP_ENQUEUE, 8'd255, 5'd16, 5'd16, 5'd16, 1'b0)); // repeated resource
      send_word(make_word(OP_ENQUEUE, 8'haa, 5'd1, 5'd0, 5'd31, 1'b0));  // none and out of range
      send_word(make_word(OP_ENQUEUE, 8'h55, 5'd2, 5'd0, 5'd0, 1'b1));   // shutdown entry
      send_word(make_word(OP_TAKE, 8'hff, 5'd31, 5'd31, 5'd31, 1'b1));   // grants tag 0
      send_word(make_word(OP_TAKE, 8'd0, 5'd0, 5'd0, 5'd0, 1'b0));       // grants 255, locks 16
      send_word(make_word(OP_TAKE, 8'd0, 5'd0, 5'd0, 5'd0, 1'b0));       // shutdown passes a blocked one
      send_word(make_word(OP_TAKE, 8'd0, 5'd0, 5'd0, 5'd0, 1'b0));       // nothing ready
      send_word(make_word(OP_RELEASE, 8'd0, 5'd1, 5'd17, 5'd0, 1'b0));   // out of range ignored
      send_word(make_word(OP_TAKE, 8'd0, 5'd0, 5'd0, 5'd0, 1'b0));       // now 0xaa goes
      send_word(make_word(OP_RELEASE, 8'hff, 5'd1, 5'd2, 5'd3, 1'b1));
      send_word(make_word(OP_RELEASE, 8'd0, 5'd16, 5'd16, 5'd4, 1'b0));  // 4 was already free
      send_word(make_word(OP_UNUSED, 8'hff, 5'd31, 5'd31, 5'd31, 1'b1));
      send_word(make_word(OP_RELEASE, 8'd0, 5'd0, 5'd0, 5'd0, 1'b0));
      send_word(make_word(OP_ENQUEUE, 8'hff, 5'd31, 5'd31, 5'd31, 1'b1));
      send_word(make_word(OP_ENQUEUE, 8'h01, 5'd16, 5'd1, 5'd8, 1'b0));
      send_word(make_word(OP_TAKE, 8'd0, 5'd0, 5'd0, 5'd0, 1'b0));
      send_word(make_word(OP_TAKE, 8'd0, 5'd0, 5'd0, 5'd0, 1'b0));
      send_word(make_word(OP_TAKE, 8'd0, 5'd0, 5'd0, 5'd0, 1'b0));
      directed_words = words_sent;

      // random part in chunks; pacing phase follows progress
      while (words_sent - directed_words < RANDOM_WORDS) begin
         case ((words_sent - directed_words) * 4 / RANDOM_WORDS)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 63; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
         endcase
         kind = $urandom_range(99);
         if (kind < 60) begin
            // ordinary traffic mix
            repeat (12) begin
               p = $urandom_range(99);
               if (p < 45) begin
                  send_random(OP_ENQUEUE);
               end else if (p < 80) begin
                  send_random(OP_TAKE);
               end else if (p < 97) begin
                  send_random(OP_RELEASE);
               end else begin
                  send_random(OP_UNUSED);
               end
            end
         end else if (kind < 75) begin
            // burst of enqueues runs into a full queue
            repeat (18) send_random(OP_ENQUEUE);
         end else if (kind < 90) begin
            // free every lock, then drain
            for (int r = 1; r <= NUM_RESOURCES; r += 3) begin
               send_word(make_word(OP_RELEASE, TAG_W'($urandom), RES_W'(r), RES_W'(r + 1),
                                   RES_W'(r + 2), $urandom_range(1)));
            end
            repeat (10) send_random(OP_TAKE);
         end else begin
            // raw noise words
            repeat (8) send_word(req_word_type'($bits(req_word_type)'($urandom)));
         end
      end
      @(negedge clock);
      req_valid = 1'b0;

      // drain outstanding responses, then let the pipeline settle
      while (words_pending != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);

      $display("%0d request words sent (%0d directed), over four pacing phases",
               words_sent, directed_words);
      $display("%0d grants and %0d full-queue rejections seen", grant_count, full_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
